// ===== design/rcfu_pkg.sv =====
// Shared types and constants of the RC link frame channel unpacker.
package rcfu_pkg;

    localparam int PAYLOAD_START = 3;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_END   = PAYLOAD_START + PAYLOAD_BYTES;
    localparam int MIN_RC_FRAME  = 26;
    localparam int CHAN_BITS     = 11;

    // one payload bank holds the 22 payload bytes of a frame; two banks
    localparam int PAY_AW  = 5;
    localparam int MEM_AW  = PAY_AW + 1;
    localparam int TOTAL_W = 9;
    localparam int ACC_W   = 18;
    localparam int NBITS_W = 5;

    localparam logic [7:0] SYNC_ADDR_RESET  = 8'hC8;
    localparam logic [7:0] FRAME_TYPE_RESET = 8'h16;

    // configuration register indexes
    localparam logic REG_SYNC_ADDR  = 1'b0;
    localparam logic REG_FRAME_TYPE = 1'b1;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic bank;
    } t_frame_cmd;

    typedef struct packed {
        logic       valid;
        t_frame_cmd cmd;
    } t_queue_head;

endpackage

// ===== design/rc_link_frame_channel_unpacker.sv =====
// Top level of the RC link frame channel unpacker.
//
//  channel   direction  handshake          payload
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//  rx byte   in         i_valid / o_stall  i_rx_byte
//  channel   out        o_valid / i_stall  o_channel_index, o_channel_value, o_last_channel
//
// One received word is taken per cycle while o_stall is low; o_stall rises only while two finished RC
// frames wait for the unpacker, one per payload bank.
// Unpacking starts from idle, reads each payload byte from the bank memory in a read and a
// load state and emits one channel per emit state, paced by the single read port.
// Reset is synchronous and active low; it returns to hunting for the sync byte.
// A stalled output holds its word; the unpacker waits while the output is full.
module rc_link_frame_channel_unpacker #(
    parameter int BUFFER_BYTES  = 64,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_channel_value,
    output logic        o_last_channel,
    input  logic        i_stall
);

    logic                  push, pop, queue_full;
    rcfu_pkg::t_frame_cmd  push_cmd;
    rcfu_pkg::t_mem_wr     mem_wr;
    rcfu_pkg::t_queue_head head;

    rcfu_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .i_queue_full (queue_full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_push_cmd   (push_cmd),
        .o_mem_wr     (mem_wr)
    );

    rcfu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_head     (head)
    );

    rcfu_back #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mem_wr        (mem_wr),
        .i_head          (head),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

// ===== design/rcfu_front.sv =====
// Front end: configuration, sync hunt, frame length tracking and payload capture.
module rcfu_front #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_queue_full,
    output logic                o_stall,
    output logic                o_push,
    output rcfu_pkg::t_frame_cmd o_push_cmd,
    output rcfu_pkg::t_mem_wr   o_mem_wr
);

    localparam int TW = $clog2(BUFFER_BYTES + 1);
    localparam logic [9:0] BUF_L = 10'(BUFFER_BYTES);

    logic [7:0]                  r_sync_addr;
    logic [7:0]                  r_type_cfg;
    logic                        r_in_frame, n_in_frame;
    logic [TW-1:0]               r_taken, n_taken;
    logic [rcfu_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [7:0]                  r_frame_type, n_frame_type;
    logic                        r_bank, n_bank;

    logic                        accept;
    logic [TW-1:0]               taken_inc;
    logic [9:0]                  taken_ext;
    logic [9:0]                  inc_ext;
    logic [rcfu_pkg::TOTAL_W-1:0] len_total;
    logic [9:0]                  pay_idx;
    logic [7:0]                  type_now;

    assign accept    = i_valid && !i_queue_full;
    assign o_stall   = i_queue_full;
    assign taken_inc = r_taken + 1'b1;
    assign taken_ext = 10'(r_taken);
    assign inc_ext   = 10'(taken_inc);
    assign len_total = rcfu_pkg::TOTAL_W'(i_rx_byte) + rcfu_pkg::TOTAL_W'(2);
    assign pay_idx   = taken_ext - 10'(rcfu_pkg::PAYLOAD_START);
    assign type_now  = (taken_ext == 10'd2) ? i_rx_byte : r_frame_type;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_taken       = r_taken;
        n_total       = r_total;
        n_frame_type  = r_frame_type;
        n_bank        = r_bank;
        o_push        = 1'b0;
        o_push_cmd.bank = r_bank;
        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = {r_bank, pay_idx[rcfu_pkg::PAY_AW-1:0]};
        o_mem_wr.data = i_rx_byte;
        if (accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == r_sync_addr) begin
                    n_in_frame = 1'b1;
                    n_taken    = TW'(1);
                end
            end else if (taken_ext >= BUF_L) begin
                n_in_frame = 1'b0;
                n_taken    = '0;
            end else begin
                n_taken = taken_inc;
                if (taken_ext == 10'd1) begin
                    n_total = len_total;
                    // drop a frame that would overrun the buffer
                    if (10'(len_total) > BUF_L) begin
                        n_in_frame = 1'b0;
                        n_taken    = '0;
                    end
                end else begin
                    if (taken_ext == 10'd2) begin
                        n_frame_type = i_rx_byte;
                    end
                    if (taken_ext >= 10'(rcfu_pkg::PAYLOAD_START) &&
                        taken_ext < 10'(rcfu_pkg::PAYLOAD_END)) begin
                        o_mem_wr.en = 1'b1;
                    end
                    if (inc_ext >= 10'(r_total)) begin
                        n_in_frame = 1'b0;
                        n_taken    = '0;
                        // hand the filled bank to the back end, write the other one next
                        if (type_now == r_type_cfg &&
                            r_total >= rcfu_pkg::TOTAL_W'(rcfu_pkg::MIN_RC_FRAME)) begin
                            o_push = 1'b1;
                            n_bank = ~r_bank;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_addr <= rcfu_pkg::SYNC_ADDR_RESET;
            r_type_cfg  <= rcfu_pkg::FRAME_TYPE_RESET;
            r_in_frame  <= 1'b0;
            r_taken     <= '0;
            r_bank      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rcfu_pkg::REG_SYNC_ADDR:  r_sync_addr <= i_cfg_data;
                    rcfu_pkg::REG_FRAME_TYPE: r_type_cfg  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_frame <= n_in_frame;
            r_taken    <= n_taken;
            r_bank     <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total      <= n_total;
        r_frame_type <= n_frame_type;
    end

endmodule

// ===== design/rcfu_queue.sv =====
// Two-entry queue of completed RC frames between front and back end.
module rcfu_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rcfu_pkg::t_frame_cmd i_push_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output rcfu_pkg::t_queue_head o_head
);

    rcfu_pkg::t_frame_cmd r_ent [0:1];
    logic                 r_wp, r_rp;
    logic [1:0]           r_count, n_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_ent[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("frame queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("frame queue underflow");

endmodule

// ===== design/rcfu_back.sv =====
// Back end: payload memory and byte-by-byte unpacking of 11-bit channel values.
module rcfu_back #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rcfu_pkg::t_mem_wr     i_mem_wr,
    input  rcfu_pkg::t_queue_head i_head,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [3:0]            o_channel_index,
    output logic [10:0]           o_channel_value,
    output logic                  o_last_channel
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [3:0] LAST_CH = 4'(CHANNEL_COUNT - 1);
    localparam logic [rcfu_pkg::NBITS_W-1:0] CB = rcfu_pkg::NBITS_W'(rcfu_pkg::CHAN_BITS);

    logic [7:0]                      r_mem [0:2**rcfu_pkg::MEM_AW-1];
    logic [7:0]                      r_rd_data;
    logic [rcfu_pkg::MEM_AW-1:0]     rd_addr;

    logic [1:0]                      r_state, n_state;
    logic [rcfu_pkg::PAY_AW-1:0]     r_k, n_k;
    logic [rcfu_pkg::NBITS_W-1:0]    r_nbits, n_nbits;
    logic [rcfu_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [3:0]                      r_ch, n_ch;
    logic                            r_out_valid, n_out_valid;
    logic [3:0]                      r_out_index, n_out_index;
    logic [10:0]                     r_out_value, n_out_value;
    logic                            r_out_last, n_out_last;

    logic                            out_free;
    logic [rcfu_pkg::ACC_W-1:0]      shifted;
    logic [rcfu_pkg::NBITS_W-1:0]    nbits_load, nbits_left;

    assign rd_addr    = {i_head.cmd.bank, r_k};
    assign out_free   = !r_out_valid || !i_stall;
    assign shifted    = rcfu_pkg::ACC_W'(r_rd_data) << r_nbits;
    assign nbits_load = r_nbits + rcfu_pkg::NBITS_W'(8);
    assign nbits_left = r_nbits - CB;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_nbits     = r_nbits;
        n_acc       = r_acc;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && i_stall;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_k     = '0;
                    n_nbits = '0;
                    n_acc   = '0;
                    n_ch    = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // append the next payload byte above the bits still held
                n_acc   = r_acc | shifted;
                n_nbits = nbits_load;
                n_k     = r_k + 1'b1;
                n_state = (nbits_load >= CB) ? S_EMIT : S_READ;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_ch;
                    n_out_value = r_acc[10:0];
                    n_out_last  = (r_ch == LAST_CH);
                    n_acc       = r_acc >> rcfu_pkg::CHAN_BITS;
                    n_nbits     = nbits_left;
                    n_ch        = r_ch + 1'b1;
                    if (r_ch == LAST_CH) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = (nbits_left >= CB) ? S_EMIT : S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_nbits     <= n_nbits;
        r_acc       <= n_acc;
        r_ch        <= n_ch;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_channel  = r_out_last;

    a_emit_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_nbits >= CB))
        else $error("channel emitted with fewer than 11 bits held");

    a_busy_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> i_head.valid)
        else $error("unpacking without a queued frame");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_channel) |-> (o_channel_index == LAST_CH))
        else $error("last flag on wrong channel");

endmodule
